### rtl/ovn_pkg.sv
package ovn_pkg;

	// Port field widths
	localparam int COORD_W    = 32;
	localparam int FREQ_W     = 24;
	localparam int PERS_W     = 17;
	localparam int CNT_W      = 4;
	localparam int SEED_W     = 16;
	localparam int HEIGHT_W   = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Internal datapath widths
	localparam int PROD_W   = COORD_W + FREQ_W; // |coord| * base frequency
	localparam int SV_W     = 48;               // scaled coordinate, Q32.16
	localparam int POS_FRAC = 16;               // fraction bits of the scaled coordinate
	localparam int LAT_W    = 32;               // lattice integer
	localparam int FRAC_W   = 17;               // signed Q16 fraction
	localparam int VAL_W    = 18;               // lattice value, Q16
	localparam int C_W      = 22;               // smoothed corner, Q20
	localparam int W_W      = 20;               // blend weight, signed Q16
	localparam int V_W      = 26;               // x-blended value, Q20
	localparam int O_W      = 25;               // one octave, Q16

	// Octave pipeline depth, from scaled product to octave value
	localparam int OCT_LAT = 14;

	// Register reset values
	localparam logic [PERS_W-1:0]        PERS_RST = PERS_W'(32768);
	localparam logic [FREQ_W-1:0]        FREQ_RST = FREQ_W'(65536);
	localparam logic [CNT_W-1:0]         CNT_RST  = CNT_W'(4);
	localparam logic signed [SEED_W-1:0] SEED_RST = '0;

	// Output saturation limits
	localparam int HEIGHT_MAX = 524288;
	localparam int HEIGHT_MIN = -524288;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERSISTENCE  = 2'd0,
		CFG_BASE_FREQ    = 2'd1,
		CFG_OCTAVE_COUNT = 2'd2,
		CFG_SEED_OFFSET  = 2'd3
	} cfg_reg_t;

endpackage

### rtl/ovn_hash.sv
module ovn_hash (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [ovn_pkg::LAT_W-1:0]            x,
	input  logic [ovn_pkg::LAT_W-1:0]            y,
	output logic signed [ovn_pkg::VAL_W-1:0]     val
);

	localparam logic [31:0] ROW_MUL = 32'd57;
	localparam logic [31:0] MUL_A   = 32'd15731;
	localparam logic [31:0] ADD_A   = 32'd789221;
	localparam logic [31:0] ADD_B   = 32'd1376312589;
	localparam logic signed [ovn_pkg::VAL_W-1:0] VAL_ONE = ovn_pkg::VAL_W'(65536);

	logic [31:0] n_raw;
	logic [31:0] t_sum;
	logic [31:0] n_s1, n_s2, n_s3;
	logic [31:0] sq_s2, u_s3, p_s4;
	logic signed [ovn_pkg::VAL_W-1:0] val_s5;

	// Fold the lattice point into one word and mix in a shifted copy
	assign n_raw = x + y * ROW_MUL;
	assign t_sum = p_s4 + ADD_B;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= (n_raw << 13) ^ n_raw;
			sq_s2  <= n_s1 * n_s1;
			n_s2   <= n_s1;
			u_s3   <= sq_s2 * MUL_A + ADD_A;
			n_s3   <= n_s2;
			p_s4   <= n_s3 * u_s3;
			// drop the sign bit, keep the top 17 bits, map to [-1, 1] in Q16
			val_s5 <= VAL_ONE - ovn_pkg::VAL_W'({1'b0, t_sum[30:14]});
		end
	end

	assign val = val_s5;

endmodule

### rtl/ovn_weight.sv
module ovn_weight (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [ovn_pkg::FRAC_W-1:0]    frac,
	output logic signed [ovn_pkg::W_W-1:0]       w0,
	output logic signed [ovn_pkg::W_W-1:0]       w1
);

	localparam logic signed [19:0] B_BASE = 20'sd196608;
	localparam logic signed [ovn_pkg::W_W-1:0] W_ONE = ovn_pkg::W_W'(65536);
	localparam logic [51:0] RND32 = 52'h0_0000_8000_0000;

	logic signed [33:0] a_sq;
	logic signed [19:0] b_nxt;
	logic [51:0]        v_rnd;
	logic [31:0]        a2_s1;
	logic [18:0]        b_s1;
	logic [50:0]        v_s2;
	logic signed [ovn_pkg::W_W-1:0] w0_s3, w1_s3;

	// 3a^2 - 2a^3 in Q48 as a^2 * (3 - 2a)
	assign a_sq  = 34'(frac) * 34'(frac);
	assign b_nxt = B_BASE - (20'(frac) <<< 1);
	assign v_rnd = 52'(v_s2) + RND32;

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s1 <= a_sq[31:0];
			b_s1  <= b_nxt[18:0];
			v_s2  <= 51'(a2_s1) * 51'(b_s1);
			w1_s3 <= signed'(v_rnd[51:32]);
			w0_s3 <= W_ONE - signed'(v_rnd[51:32]);
		end
	end

	assign w0 = w0_s3;
	assign w1 = w1_s3;

endmodule

### rtl/ovn_octave.sv
module ovn_octave #(
	parameter int K               = 0,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [ovn_pkg::PROD_W-1:0]            prod_x,
	input  logic                                  neg_x,
	input  logic [ovn_pkg::PROD_W-1:0]            prod_y,
	input  logic                                  neg_y,
	input  logic signed [ovn_pkg::SEED_W-1:0]     seed,
	output logic signed [ovn_pkg::O_W-1:0]        oct_val
);

	localparam int SHL  = (K >= COORD_FRAC_BITS) ? (K - COORD_FRAC_BITS) : 0;
	localparam int SHR  = (K >= COORD_FRAC_BITS) ? 0 : (COORD_FRAC_BITS - K);
	localparam int SV_W = ovn_pkg::SV_W;
	localparam int XP_W = ovn_pkg::C_W + ovn_pkg::W_W;
	localparam int XS_W = XP_W + 1;
	localparam int YP_W = ovn_pkg::V_W + ovn_pkg::W_W;
	localparam int YS_W = YP_W + 1;
	localparam logic signed [XS_W-1:0] RND16 = XS_W'(32768);
	localparam logic signed [YS_W-1:0] RND20 = YS_W'(524288);

	logic [63:0]     wide_x, wide_y;
	logic [SV_W-1:0] sh_x, sh_y, seed_sv;

	logic [SV_W-1:0] sv_x_s1, sv_y_s1;
	logic [SV_W-1:0] mag_x_s2, mag_y_s2;
	logic            sgn_x_s2, sgn_y_s2;
	logic [ovn_pkg::LAT_W-1:0] lat_x_s3, lat_y_s3;
	logic signed [ovn_pkg::FRAC_W-1:0] frac_x_s3, frac_y_s3;
	logic [ovn_pkg::LAT_W-1:0] xo_s4 [0:3];
	logic [ovn_pkg::LAT_W-1:0] yo_s4 [0:3];
	logic signed [ovn_pkg::FRAC_W-1:0] fx_s [4:7];
	logic signed [ovn_pkg::FRAC_W-1:0] fy_s [4:9];

	logic signed [ovn_pkg::VAL_W-1:0] nv [0:3][0:3];
	logic signed [ovn_pkg::C_W-1:0]   corner_nxt [0:1][0:1];
	logic signed [ovn_pkg::C_W-1:0]   corner_s10 [0:1][0:1];
	logic signed [ovn_pkg::W_W-1:0]   wx0, wx1, wy0, wy1;

	logic signed [XP_W-1:0] xa_s11, xb_s11, xc_s11, xd_s11;
	logic signed [ovn_pkg::V_W-1:0] v1_s12, v2_s12;
	logic signed [YP_W-1:0] ya_s13, yb_s13;
	logic signed [ovn_pkg::O_W-1:0] oct_val_s14;

	// Scale by 2^K relative to the coordinate fraction, keep 16 fraction bits
	assign wide_x  = 64'(prod_x);
	assign wide_y  = 64'(prod_y);
	assign sh_x    = SV_W'((wide_x << SHL) >> SHR);
	assign sh_y    = SV_W'((wide_y << SHL) >> SHR);
	assign seed_sv = {{(SV_W - ovn_pkg::SEED_W - ovn_pkg::POS_FRAC){seed[ovn_pkg::SEED_W-1]}},
		seed, {ovn_pkg::POS_FRAC{1'b0}}};

	// Apply the sign, add the seed, split toward zero
	always_ff @(posedge clk) begin
		if (en) begin
			sv_x_s1   <= neg_x ? (seed_sv - sh_x) : (seed_sv + sh_x);
			sv_y_s1   <= neg_y ? (seed_sv - sh_y) : (seed_sv + sh_y);
			sgn_x_s2  <= sv_x_s1[SV_W-1];
			sgn_y_s2  <= sv_y_s1[SV_W-1];
			mag_x_s2  <= sv_x_s1[SV_W-1] ? (SV_W'(0) - sv_x_s1) : sv_x_s1;
			mag_y_s2  <= sv_y_s1[SV_W-1] ? (SV_W'(0) - sv_y_s1) : sv_y_s1;
			lat_x_s3  <= sgn_x_s2 ? (ovn_pkg::LAT_W'(0) - mag_x_s2[SV_W-1:ovn_pkg::POS_FRAC])
				: mag_x_s2[SV_W-1:ovn_pkg::POS_FRAC];
			lat_y_s3  <= sgn_y_s2 ? (ovn_pkg::LAT_W'(0) - mag_y_s2[SV_W-1:ovn_pkg::POS_FRAC])
				: mag_y_s2[SV_W-1:ovn_pkg::POS_FRAC];
			frac_x_s3 <= sgn_x_s2 ? -signed'({1'b0, mag_x_s2[ovn_pkg::POS_FRAC-1:0]})
				: signed'({1'b0, mag_x_s2[ovn_pkg::POS_FRAC-1:0]});
			frac_y_s3 <= sgn_y_s2 ? -signed'({1'b0, mag_y_s2[ovn_pkg::POS_FRAC-1:0]})
				: signed'({1'b0, mag_y_s2[ovn_pkg::POS_FRAC-1:0]});
		end
	end

	// Neighbor lattice rows and columns, offsets -1..2; hold fractions for the weights
	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 4; d++) begin
				xo_s4[d] <= lat_x_s3 + ovn_pkg::LAT_W'(d - 1);
				yo_s4[d] <= lat_y_s3 + ovn_pkg::LAT_W'(d - 1);
			end
			fx_s[4] <= frac_x_s3;
			fy_s[4] <= frac_y_s3;
			for (int s = 5; s <= 7; s++) begin
				fx_s[s] <= fx_s[s-1];
			end
			for (int s = 5; s <= 9; s++) begin
				fy_s[s] <= fy_s[s-1];
			end
		end
	end

	// Sixteen lattice values
	for (genvar dy = 0; dy < 4; dy++) begin : g_row
		for (genvar dx = 0; dx < 4; dx++) begin : g_col
			ovn_hash u_hash (
				.clk (clk),
				.en  (en),
				.x   (xo_s4[dx]),
				.y   (yo_s4[dy]),
				.val (nv[dy][dx])
			);
		end
	end

	// Smoothstep weights, x ready at stage 10, y at stage 12
	ovn_weight u_wx (
		.clk  (clk),
		.en   (en),
		.frac (fx_s[7]),
		.w0   (wx0),
		.w1   (wx1)
	);

	ovn_weight u_wy (
		.clk  (clk),
		.en   (en),
		.frac (fy_s[9]),
		.w0   (wy0),
		.w1   (wy1)
	);

	// 3x3 smoothing of each corner: 1 at diagonals, 2 at edges, 4 at center
	always_comb begin
		for (int cy = 0; cy < 2; cy++) begin
			for (int cx = 0; cx < 2; cx++) begin
				corner_nxt[cy][cx] = ovn_pkg::C_W'(nv[cy][cx]) + ovn_pkg::C_W'(nv[cy][cx+2])
					+ ovn_pkg::C_W'(nv[cy+2][cx]) + ovn_pkg::C_W'(nv[cy+2][cx+2])
					+ ((ovn_pkg::C_W'(nv[cy+1][cx]) + ovn_pkg::C_W'(nv[cy+1][cx+2])
					+ ovn_pkg::C_W'(nv[cy][cx+1]) + ovn_pkg::C_W'(nv[cy+2][cx+1])) <<< 1)
					+ (ovn_pkg::C_W'(nv[cy+1][cx+1]) <<< 2);
			end
		end
	end

	// Blend along x, then along y
	always_ff @(posedge clk) begin
		if (en) begin
			corner_s10  <= corner_nxt;
			xa_s11      <= XP_W'(corner_s10[0][0]) * XP_W'(wx0);
			xb_s11      <= XP_W'(corner_s10[0][1]) * XP_W'(wx1);
			xc_s11      <= XP_W'(corner_s10[1][0]) * XP_W'(wx0);
			xd_s11      <= XP_W'(corner_s10[1][1]) * XP_W'(wx1);
			v1_s12      <= ovn_pkg::V_W'((XS_W'(xa_s11) + XS_W'(xb_s11) + RND16) >>> 16);
			v2_s12      <= ovn_pkg::V_W'((XS_W'(xc_s11) + XS_W'(xd_s11) + RND16) >>> 16);
			ya_s13      <= YP_W'(v1_s12) * YP_W'(wy0);
			yb_s13      <= YP_W'(v2_s12) * YP_W'(wy1);
			oct_val_s14 <= ovn_pkg::O_W'((YS_W'(ya_s13) + YS_W'(yb_s13) + RND20) >>> 20);
		end
	end

	assign oct_val = oct_val_s14;

endmodule

### rtl/octave_value_noise_2d_core.sv
// Throughput: one sample per cycle while the skid entry is free; all octaves run side
// by side and a registered adder tree sums them, so the depth is set by the hash and
// blend multipliers. A two-entry output stage keeps input ready high into an output
// stall until a sample reaches the stalled output and fills the skid entry.
// Reset clears all valid bits and loads the register defaults; the octave amplitude
// chain has no reset and settles through its registers before any sample reaches it.
module octave_value_noise_2d_core #(
	parameter int MAX_OCTAVES     = 8,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [ovn_pkg::COORD_W-1:0]     row_coord,
	input  logic signed [ovn_pkg::COORD_W-1:0]     col_coord,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ovn_pkg::HEIGHT_W-1:0]    height,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ovn_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ovn_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int TREE_LVL = $clog2(MAX_OCTAVES);
	localparam int TREE_N   = 1 << TREE_LVL;
	localparam int AMP_W    = MAX_OCTAVES + 16;
	localparam int AMP_PW   = AMP_W + ovn_pkg::PERS_W;
	localparam int TERM_W   = ovn_pkg::O_W + AMP_W + 1;
	localparam int ACC_W    = TERM_W + TREE_LVL;
	localparam int PIPE_LAT = 2 + ovn_pkg::OCT_LAT + 1 + TREE_LVL + 1;
	localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] H_MAX = ACC_W'(ovn_pkg::HEIGHT_MAX);
	localparam logic signed [ACC_W-1:0] H_MIN = ACC_W'(ovn_pkg::HEIGHT_MIN);
	localparam logic signed [ovn_pkg::HEIGHT_W-1:0] HO_MAX =
		ovn_pkg::HEIGHT_W'(ovn_pkg::HEIGHT_MAX);
	localparam logic signed [ovn_pkg::HEIGHT_W-1:0] HO_MIN =
		ovn_pkg::HEIGHT_W'(ovn_pkg::HEIGHT_MIN);

	// Configuration registers
	logic [ovn_pkg::PERS_W-1:0]        persistence_q;
	logic [ovn_pkg::FREQ_W-1:0]        base_frequency_q;
	logic [ovn_pkg::CNT_W-1:0]         octave_count_q;
	logic signed [ovn_pkg::SEED_W-1:0] seed_offset_q;

	logic en;
	logic [PIPE_LAT-1:0] vld_q;
	logic v_last;

	logic [ovn_pkg::COORD_W-1:0] mag_row_s1, mag_col_s1;
	logic neg_row_s1, neg_col_s1;
	logic [ovn_pkg::PROD_W-1:0] prod_row_s2, prod_col_s2;
	logic neg_row_s2, neg_col_s2;

	logic signed [ovn_pkg::O_W-1:0] oct_val [0:MAX_OCTAVES-1];
	logic [AMP_W-1:0]               amp_w [0:MAX_OCTAVES-1];
	logic signed [ACC_W-1:0]        term_nxt [0:TREE_N-1];
	logic signed [ACC_W-1:0]        tree_s3 [0:TREE_LVL][0:TREE_N-1];
	logic signed [ACC_W-1:0]        acc_rnd;
	logic signed [ovn_pkg::HEIGHT_W-1:0] height_s4;

	logic out_vld_q, skid_vld_q;
	logic signed [ovn_pkg::HEIGHT_W-1:0] height_q, skid_h_q;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			persistence_q    <= ovn_pkg::PERS_RST;
			base_frequency_q <= ovn_pkg::FREQ_RST;
			octave_count_q   <= ovn_pkg::CNT_RST;
			seed_offset_q    <= ovn_pkg::SEED_RST;
		end else if (cfg_valid) begin
			case (ovn_pkg::cfg_reg_t'(cfg_index))
				ovn_pkg::CFG_PERSISTENCE:  persistence_q    <= cfg_data[ovn_pkg::PERS_W-1:0];
				ovn_pkg::CFG_BASE_FREQ:    base_frequency_q <= cfg_data[ovn_pkg::FREQ_W-1:0];
				ovn_pkg::CFG_OCTAVE_COUNT: octave_count_q   <= cfg_data[ovn_pkg::CNT_W-1:0];
				ovn_pkg::CFG_SEED_OFFSET:  seed_offset_q    <= signed'(cfg_data[ovn_pkg::SEED_W-1:0]);
				default: ;
			endcase
		end
	end

	// Pipeline advances whenever the skid entry is free
	assign en       = !skid_vld_q;
	assign in_ready = en;
	assign v_last   = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// Take magnitudes, then scale by the base frequency once for all octaves
	always_ff @(posedge clk) begin
		if (en) begin
			neg_row_s1  <= row_coord[ovn_pkg::COORD_W-1];
			neg_col_s1  <= col_coord[ovn_pkg::COORD_W-1];
			mag_row_s1  <= row_coord[ovn_pkg::COORD_W-1] ? ovn_pkg::COORD_W'(-row_coord)
				: ovn_pkg::COORD_W'(row_coord);
			mag_col_s1  <= col_coord[ovn_pkg::COORD_W-1] ? ovn_pkg::COORD_W'(-col_coord)
				: ovn_pkg::COORD_W'(col_coord);
			prod_row_s2 <= ovn_pkg::PROD_W'(mag_row_s1) * ovn_pkg::PROD_W'(base_frequency_q);
			prod_col_s2 <= ovn_pkg::PROD_W'(mag_col_s1) * ovn_pkg::PROD_W'(base_frequency_q);
			neg_row_s2  <= neg_row_s1;
			neg_col_s2  <= neg_col_s1;
		end
	end

	// One octave pipeline per octave, plus its amplitude from the persistence chain
	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
		ovn_octave #(
			.K               (k),
			.COORD_FRAC_BITS (COORD_FRAC_BITS)
		) u_octave (
			.clk     (clk),
			.en      (en),
			.prod_x  (prod_col_s2),
			.neg_x   (neg_col_s2),
			.prod_y  (prod_row_s2),
			.neg_y   (neg_row_s2),
			.seed    (seed_offset_q),
			.oct_val (oct_val[k])
		);

		if (k == 0) begin : g_amp0
			assign amp_w[k] = AMP_W'(65536);
		end else begin : g_ampk
			logic [AMP_W-1:0] amp_q;
			always_ff @(posedge clk) begin
				amp_q <= AMP_W'((AMP_PW'(amp_w[k-1]) * AMP_PW'(persistence_q)) >> 16);
			end
			assign amp_w[k] = amp_q;
		end
	end

	// Weighted octave terms; octaves at or above the count contribute zero
	for (genvar k = 0; k < TREE_N; k++) begin : g_term
		if (k < MAX_OCTAVES) begin : g_live
			logic signed [TERM_W-1:0] term;
			assign term = TERM_W'(oct_val[k]) * TERM_W'(signed'({1'b0, amp_w[k]}));
			assign term_nxt[k] = (ovn_pkg::CNT_W'(k) < octave_count_q) ? ACC_W'(term) : '0;
		end else begin : g_pad
			assign term_nxt[k] = '0;
		end
	end

	// Registered adder tree, each level held in its own register
	always_ff @(posedge clk) begin
		if (en) begin
			tree_s3[0] <= term_nxt;
			for (int l = 1; l <= TREE_LVL; l++) begin
				for (int i = 0; i < (TREE_N >> l); i++) begin
					tree_s3[l][i] <= tree_s3[l-1][2*i] + tree_s3[l-1][2*i+1];
				end
			end
		end
	end

	// Round to Q16 and saturate
	assign acc_rnd = (tree_s3[TREE_LVL][0] + RND16) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			height_s4 <= (acc_rnd > H_MAX) ? HO_MAX
				: (acc_rnd < H_MIN) ? HO_MIN : acc_rnd[ovn_pkg::HEIGHT_W-1:0];
		end
	end

	// Output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= v_last;
			end
		end else if (v_last && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			height_q <= skid_vld_q ? skid_h_q : height_s4;
		end
		if (out_vld_q && !out_ready && !skid_vld_q) begin
			skid_h_q <= height_s4;
		end
	end

	assign out_valid = out_vld_q;
	assign height    = height_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int NOISE_OCTAVES = 8;
	localparam int IDLE_LIMIT    = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 40;

	// Noise-height predictor and queue of pending heights
	class height_board;
		logic [ovn_pkg::PERS_W-1:0]        pers;
		logic [ovn_pkg::FREQ_W-1:0]        freq;
		logic [ovn_pkg::CNT_W-1:0]         octaves;
		logic signed [ovn_pkg::SEED_W-1:0] seed;
		logic signed [ovn_pkg::HEIGHT_W-1:0] pending_heights[$];
		int errors;

		function new();
			pers = ovn_pkg::PERS_RST;
			freq = ovn_pkg::FREQ_RST;
			octaves = ovn_pkg::CNT_RST;
			seed = ovn_pkg::SEED_RST;
			errors = 0;
		endfunction

		function void write_reg(ovn_pkg::cfg_reg_t idx, logic [ovn_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ovn_pkg::CFG_PERSISTENCE:  pers = data[ovn_pkg::PERS_W-1:0];
				ovn_pkg::CFG_BASE_FREQ:    freq = data[ovn_pkg::FREQ_W-1:0];
				ovn_pkg::CFG_OCTAVE_COUNT: octaves = data[ovn_pkg::CNT_W-1:0];
				ovn_pkg::CFG_SEED_OFFSET:  seed = data[ovn_pkg::SEED_W-1:0];
				default: ;
			endcase
		endfunction

		// Scale by frequency * 2^k, add seed, split toward zero
		function void split_pos(logic [31:0] raw, int k, output logic [31:0] lat,
				output longint frac);
			longint c;
			bit neg;
			logic [63:0] mag, s, m, ip;
			longint sv;
			c = longint'($signed(raw));
			neg = c < 0;
			mag = neg ? 64'(-c) : 64'(c);
			s = (mag * 64'(freq)) >> (16 - k);
			if (neg)
				s = -s;
			s = s + (64'(longint'(seed)) << 16);
			sv = longint'($signed(s[47:0]));
			m = sv < 0 ? 64'(-sv) : 64'(sv);
			ip = m >> 16;
			if (sv < 0) begin
				lat = -ip[31:0];
				frac = -longint'(m[15:0]);
			end else begin
				lat = ip[31:0];
				frac = longint'(m[15:0]);
			end
		endfunction

		function longint hash_value(int unsigned x, int unsigned y);
			int unsigned n, t;
			n = x + y * 32'd57;
			n = (n << 13) ^ n;
			t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
			return 65536 - longint'(t >> 14);
		endfunction

		function longint smooth_weight(longint a);
			longint a2, a3;
			a2 = a * a;
			a3 = a2 * a;
			return (3 * a2 * 65536 - 2 * a3 + (longint'(1) << 31)) >>> 32;
		endfunction

		function longint octave_value(logic [31:0] row, logic [31:0] col, int k);
			logic [31:0] xi, yi;
			longint xf, yf, c00, c10, c01, c11, wx1, wx0, wy1, wy0, v1, v2;
			longint n[4][4];
			split_pos(col, k, xi, xf);
			split_pos(row, k, yi, yf);
			for (int dy = 0; dy < 4; dy++)
				for (int dx = 0; dx < 4; dx++)
					n[dy][dx] = hash_value(xi + 32'(dx - 1), yi + 32'(dy - 1));
			c00 = n[0][0] + n[0][2] + n[2][0] + n[2][2]
				+ 2 * (n[1][0] + n[1][2] + n[0][1] + n[2][1]) + 4 * n[1][1];
			c10 = n[0][1] + n[0][3] + n[2][1] + n[2][3]
				+ 2 * (n[1][1] + n[1][3] + n[0][2] + n[2][2]) + 4 * n[1][2];
			c01 = n[1][0] + n[1][2] + n[3][0] + n[3][2]
				+ 2 * (n[2][0] + n[2][2] + n[1][1] + n[3][1]) + 4 * n[2][1];
			c11 = n[1][1] + n[1][3] + n[3][1] + n[3][3]
				+ 2 * (n[2][1] + n[2][3] + n[1][2] + n[3][2]) + 4 * n[2][2];
			wx1 = smooth_weight(xf);
			wx0 = 65536 - wx1;
			wy1 = smooth_weight(yf);
			wy0 = 65536 - wy1;
			v1 = (c00 * wx0 + c10 * wx1 + 32768) >>> 16;
			v2 = (c01 * wx0 + c11 * wx1 + 32768) >>> 16;
			return (v1 * wy0 + v2 * wy1 + (longint'(1) << 19)) >>> 20;
		endfunction

		// Sum weighted octaves, round, saturate; queue the height
		function void note_sample(logic [31:0] row, logic [31:0] col);
			int cnt;
			longint amp, acc, h;
			cnt = octaves > NOISE_OCTAVES ? NOISE_OCTAVES : int'(octaves);
			amp = 65536;
			acc = 0;
			for (int k = 0; k < cnt; k++) begin
				acc += octave_value(row, col, k) * amp;
				amp = (amp * longint'(pers)) >> 16;
			end
			h = (acc + 32768) >>> 16;
			if (h > ovn_pkg::HEIGHT_MAX)
				h = ovn_pkg::HEIGHT_MAX;
			if (h < ovn_pkg::HEIGHT_MIN)
				h = ovn_pkg::HEIGHT_MIN;
			pending_heights.push_back(h[ovn_pkg::HEIGHT_W-1:0]);
		endfunction

		function void check_height(logic signed [ovn_pkg::HEIGHT_W-1:0] got);
			logic signed [ovn_pkg::HEIGHT_W-1:0] want;
			if (pending_heights.size() == 0) begin
				$error("height %0d arrived with nothing pending", got);
				errors++;
				return;
			end
			want = pending_heights.pop_front();
			if (got !== want) begin
				$error("height expected %0d got %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [ovn_pkg::COORD_W-1:0] row_coord = '0;
	logic signed [ovn_pkg::COORD_W-1:0] col_coord = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [ovn_pkg::HEIGHT_W-1:0] height;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ovn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ovn_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	height_board board = new();
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_req = 1'b0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	octave_value_noise_2d_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.row_coord(row_coord), .col_coord(col_coord),
		.out_valid(out_valid), .out_ready(out_ready), .height(height),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("octave_value_noise_2d_core verification failed");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else begin
				stall = recv_idle ? $urandom_range(0, 13) : 0;
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (!out_valid);
			board.check_height(height);
		end
	end

	task automatic send_sample(logic [31:0] r, logic [31:0] c);
		int gap;
		gap = send_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_coord <= r;
		col_coord <= c;
		do @(posedge clk); while (!in_ready);
		board.note_sample(r, c);
	endtask

	// Hold valid high across back-to-back writes; the caller drops it
	task automatic write_cfg(ovn_pkg::cfg_reg_t idx, logic [ovn_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
	endtask

	// Hold the sender until every pending height has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_heights.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_all(int p, int f, int o, int s);
		write_cfg(ovn_pkg::CFG_PERSISTENCE, ovn_pkg::CFG_DATA_W'(p));
		write_cfg(ovn_pkg::CFG_BASE_FREQ, ovn_pkg::CFG_DATA_W'(f));
		write_cfg(ovn_pkg::CFG_OCTAVE_COUNT, ovn_pkg::CFG_DATA_W'(o));
		write_cfg(ovn_pkg::CFG_SEED_OFFSET, 24'(s) & 24'hFFFF);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 9) < 6)
			return 32'($signed(32'($urandom_range(0, 16 << 16)))) - 32'(8 << 16);
		return $urandom();
	endfunction

	task automatic random_samples(int count);
		for (int i = 0; i < count; i++)
			send_sample(rand_coord(), rand_coord());
	endtask

	initial begin
		logic [31:0] edge_vals[10];
		edge_vals = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1,
			32'h00008000, 32'hffff8000, 32'h00010000, 32'hfffeffff, 32'h0000ffff};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: coordinate extremes at reset defaults
		for (int i = 0; i < 10; i++)
			send_sample(edge_vals[i], edge_vals[9 - i]);
		drain();

		// Full persistence, largest frequency, all octaves, lowest seed
		set_all(65536, 24'hFFFFFF, 8, -32768);
		for (int i = 0; i < 5; i++)
			send_sample(edge_vals[i], edge_vals[i + 5]);
		drain();

		// Zero octaves, zero frequency, highest seed
		set_all(0, 0, 0, 32767);
		send_sample(32'h7fffffff, 32'h80000000);
		send_sample(32'h12345678, 32'hdeadbeef);
		drain();

		// Count above the octave limit clamps
		set_all(65536, 65536, 15, 0);
		for (int i = 0; i < 5; i++)
			send_sample(edge_vals[2 * i], edge_vals[2 * i + 1]);
		drain();

		// Input back-pressure: no gaps while the result side holds off
		send_idle = 1'b0;
		hold_req = 1'b1;
		random_samples(150);
		drain();
		send_idle = 1'b1;

		// Random settings
		for (int ph = 0; ph < 8; ph++) begin
			set_all($urandom_range(0, 65536),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
					: $urandom_range(0, 4 << 16),
				$urandom_range(0, 15), $signed(16'($urandom())));
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			random_samples(175);
			drain();
		end

		if (board.errors == 0)
			$display("octave_value_noise_2d_core verification clean");
		else
			$display("octave_value_noise_2d_core verification failed");
		$finish;
	end

endmodule
